>>> hdl/gasu_pkg.sv
// shared types, codes and step tables of the grid path search unit
package gasu_pkg;

  localparam int GridDim   = 16;
  localparam int CellCount = GridDim * GridDim;
  localparam int OpenDepth = 512;
  localparam int CellW     = 8;
  localparam int CostW     = 12;
  localparam int FW        = 13;
  localparam int OpenAw    = 9;
  localparam int PathLenW  = 9;
  localparam logic [CostW-1:0] CostMax = 12'd4095;

  // command codes carried in the input word
  typedef enum logic [1:0] {
    OP_WALL   = 2'd0,
    OP_SEARCH = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOPATH   = 2'd1,
    STAT_OVERFLOW = 2'd2
  } stat_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GRID_W = 3'd0,
    REG_GRID_H = 3'd1,
    REG_START_X = 3'd2,
    REG_START_Y = 3'd3,
    REG_END_X  = 3'd4,
    REG_END_Y  = 3'd5,
    REG_SCOST  = 3'd6,
    REG_DCOST  = 3'd7
  } reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_SEED, S_POP, S_SCAN, S_SHIFT, S_CHK,
    S_NB, S_NBE, S_PW, S_PR, S_PRD, S_DONE
  } state_t;

  typedef struct packed {
    logic [4:0] grid_width;
    logic [4:0] grid_height;
    logic [3:0] start_x;
    logic [3:0] start_y;
    logic [3:0] end_x;
    logic [3:0] end_y;
    logic [3:0] straight_cost;
    logic [3:0] diagonal_cost;
  } cfg_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [7:0] path_index;
  } cmd_t;

  typedef struct packed {
    stat_t               status;
    logic [PathLenW-1:0] path_length;
    logic [3:0]          point_x;
    logic [3:0]          point_y;
  } res_t;

  // open list entry
  typedef struct packed {
    logic [CellW-1:0] loc;
    logic [CostW-1:0] g;
    logic [FW-1:0]    f;
  } open_ent_t;

  // per cell cost entry
  typedef struct packed {
    logic             seen;
    logic [CostW-1:0] best;
  } cost_ent_t;

  // x offset of move k, two's complement
  function automatic logic [1:0] step_dx(input logic [2:0] k);
    logic [1:0] d;
    case (k)
      3'd0, 3'd1, 3'd2: d = 2'b11;
      3'd3, 3'd4:       d = 2'b00;
      default:          d = 2'b01;
    endcase
    return d;
  endfunction

  // y offset of move k, two's complement
  function automatic logic [1:0] step_dy(input logic [2:0] k);
    logic [1:0] d;
    case (k)
      3'd0, 3'd3, 3'd5: d = 2'b11;
      3'd1, 3'd6:       d = 2'b00;
      default:          d = 2'b01;
    endcase
    return d;
  endfunction

  function automatic logic is_diag(input logic [2:0] k);
    return (step_dx(k) != 2'b00) && (step_dy(k) != 2'b00);
  endfunction

  function automatic logic [3:0] absdiff4(input logic [3:0] a, input logic [3:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // manhattan distance to the goal
  function automatic logic [4:0] heur(input logic [CellW-1:0] c, input cfg_t cfg);
    return {1'b0, absdiff4(c[3:0], cfg.end_x)} + {1'b0, absdiff4(c[7:4], cfg.end_y)};
  endfunction

  function automatic logic [4:0] clamp_dim(input logic [4:0] v);
    logic [4:0] r;
    if (v == 5'd0) r = 5'd1;
    else if (v > 5'(GridDim)) r = 5'(GridDim);
    else r = v;
    return r;
  endfunction

endpackage

>>> hdl/gasu_ram.sv
// generic single write port ram with registered read
module gasu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/gasu_engine.sv
// search sequencer with wall, cost, parent, open list and path memories
module gasu_engine
  import gasu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  state_t state_r, state_nxt;

  logic [8:0]          clr_r, clr_nxt;
  logic [9:0]          ocnt_r, ocnt_nxt;
  logic [9:0]          ri_r, ri_nxt;
  logic                pv_r, pv_nxt;
  logic [OpenAw-1:0]   wa_r, wa_nxt;
  logic [OpenAw-1:0]   pick_r, pick_nxt;
  logic [FW-1:0]       bestf_r, bestf_nxt;
  open_ent_t           cur_r, cur_nxt;
  logic [2:0]          k_r, k_nxt;
  logic [CellW-1:0]    nc_r, nc_nxt;
  logic [PathLenW-1:0] pc_r, pc_nxt;
  logic [PathLenW-1:0] pn_r, pn_nxt;
  logic [CellW-1:0]    pcell_r, pcell_nxt;
  logic [1:0]          op_r, op_nxt;
  stat_t               status_r, status_nxt;
  logic [CellW-1:0]    pt_r, pt_nxt;

  // memory ports
  logic              wall_we, wall_wd, wall_rd;
  logic [7:0]        wall_wa, wall_ra;
  logic              cost_we;
  logic [7:0]        cost_wa, cost_ra;
  cost_ent_t         cost_wd, cost_rd;
  logic              par_we;
  logic [7:0]        par_wa, par_ra;
  logic [2:0]        par_wd, par_rd;
  logic              open_we;
  logic [OpenAw-1:0] open_wa, open_ra;
  open_ent_t         open_wd, open_rd;
  logic              path_we;
  logic [7:0]        path_wa, path_ra, path_wd, path_rd;

  // shared decode
  logic [4:0]       w, h;
  logic [CellW-1:0] s_cell, e_cell;
  logic             area_bad, wall_in, rd_ok, nb_in, nb_skip;
  logic [1:0]       mdx, mdy, pdx, pdy;
  logic [5:0]       nx6, ny6;
  logic [CellW-1:0] nb_cell;
  logic [CostW:0]   sum13;
  logic [CostW-1:0] ng;
  logic [3:0]       step_cost;
  logic             take;
  logic [9:0]       ri_m1;

  assign w       = clamp_dim(cfg.grid_width);
  assign h       = clamp_dim(cfg.grid_height);
  assign s_cell  = {cfg.start_y, cfg.start_x};
  assign e_cell  = {cfg.end_y, cfg.end_x};
  assign area_bad = ({1'b0, cfg.start_x} >= w) || ({1'b0, cfg.start_y} >= h) ||
                    ({1'b0, cfg.end_x} >= w) || ({1'b0, cfg.end_y} >= h);
  assign wall_in = ({1'b0, cmd.cell_x} < w) && ({1'b0, cmd.cell_y} < h);
  assign rd_ok   = {1'b0, cmd.path_index} < pc_r;

  // move offsets of the neighbor under test and of the parent link
  assign mdx = step_dx(k_r);
  assign mdy = step_dy(k_r);
  assign pdx = step_dx(par_rd);
  assign pdy = step_dy(par_rd);

  // neighbor of the current cell in direction k
  assign nx6     = {2'b00, cur_r.loc[3:0]} + {{4{mdx[1]}}, mdx};
  assign ny6     = {2'b00, cur_r.loc[7:4]} + {{4{mdy[1]}}, mdy};
  assign nb_in   = !nx6[5] && !ny6[5] && (nx6[4:0] < w) && (ny6[4:0] < h);
  assign nb_cell = {ny6[3:0], nx6[3:0]};

  // saturated candidate cost for the neighbor under test
  assign step_cost = is_diag(k_r) ? cfg.diagonal_cost : cfg.straight_cost;
  assign sum13     = {1'b0, cur_r.g} + {9'b0, step_cost};
  assign ng        = sum13[CostW] ? CostMax : sum13[CostW-1:0];
  assign nb_skip   = wall_rd || (cost_rd.seen && (cost_rd.best <= ng));

  // scan compare, ties go to the later entry
  assign ri_m1 = ri_r - 10'd1;
  assign take  = (ri_r == 10'd1) || (open_rd.f <= bestf_r);

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  // result fields
  always_comb begin
    res.status      = status_r;
    res.path_length = ((op_r == OP_SEARCH) || (op_r == OP_READ)) ? pc_r : '0;
    res.point_x     = pt_r[3:0];
    res.point_y     = pt_r[7:4];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: if (clr_r == 9'd255) state_nxt = S_IDLE;
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.opcode)
            OP_SEARCH: state_nxt = area_bad ? S_DONE : S_CLR;
            OP_READ:   state_nxt = rd_ok ? S_PRD : S_DONE;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_CLR:  if (clr_r == 9'd255) state_nxt = S_SEED;
      S_SEED: state_nxt = S_POP;
      S_POP:  state_nxt = (ocnt_r == 10'd0) ? S_DONE : S_SCAN;
      S_SCAN: if (ri_r == ocnt_r) state_nxt = S_SHIFT;
      S_SHIFT: if (!pv_r && (ri_r >= ocnt_r)) state_nxt = S_CHK;
      S_CHK: begin
        if (cost_rd.best != cur_r.g) state_nxt = S_POP;
        else if (cur_r.loc == e_cell) state_nxt = S_PW;
        else state_nxt = S_NB;
      end
      S_NB: begin
        if (nb_in) state_nxt = S_NBE;
        else if (k_r == 3'd7) state_nxt = S_POP;
      end
      S_NBE: begin
        if (!nb_skip && ocnt_r[9]) state_nxt = S_DONE;
        else state_nxt = (k_r == 3'd7) ? S_POP : S_NB;
      end
      S_PW: begin
        if (pn_r[8] || (pcell_r == s_cell)) state_nxt = S_DONE;
        else state_nxt = S_PR;
      end
      S_PR:   state_nxt = S_PW;
      S_PRD:  state_nxt = S_DONE;
      S_DONE: if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_nxt    = clr_r;
    ocnt_nxt   = ocnt_r;
    ri_nxt     = ri_r;
    pv_nxt     = pv_r;
    wa_nxt     = wa_r;
    pick_nxt   = pick_r;
    bestf_nxt  = bestf_r;
    cur_nxt    = cur_r;
    k_nxt      = k_r;
    nc_nxt     = nc_r;
    pc_nxt     = pc_r;
    pn_nxt     = pn_r;
    pcell_nxt  = pcell_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    pt_nxt     = pt_r;

    wall_we = 1'b0; wall_wa = clr_r[7:0]; wall_wd = 1'b0; wall_ra = nb_cell;
    cost_we = 1'b0; cost_wa = clr_r[7:0]; cost_wd = '0;   cost_ra = nb_cell;
    par_we  = 1'b0; par_wa  = nc_r;       par_wd  = k_r;  par_ra  = pcell_r;
    open_we = 1'b0; open_wa = ocnt_r[OpenAw-1:0]; open_wd = '0;
    open_ra = ri_r[OpenAw-1:0];
    path_we = 1'b0; path_wa = pn_r[7:0]; path_wd = pcell_r;
    path_ra = 8'(pc_r - 9'd1 - {1'b0, cmd.path_index});

    case (state_r)
      // wall map sweep after reset
      S_INIT: begin
        wall_we = 1'b1;
        clr_nxt = clr_r + 9'd1;
      end
      // take a command
      S_IDLE: begin
        op_nxt     = cmd.opcode;
        status_nxt = STAT_OK;
        pt_nxt     = '0;
        clr_nxt    = '0;
        if (cmd_valid) begin
          case (cmd.opcode)
            OP_WALL: begin
              wall_we = wall_in;
              wall_wa = {cmd.cell_y, cmd.cell_x};
              wall_wd = 1'b1;
            end
            OP_SEARCH: begin
              pc_nxt = '0;
              if (area_bad) status_nxt = STAT_NOPATH;
            end
            default: ;
          endcase
        end
      end
      // cost map sweep per search
      S_CLR: begin
        cost_we = 1'b1;
        clr_nxt = clr_r + 9'd1;
      end
      // start cell goes on the open list
      S_SEED: begin
        cost_we      = 1'b1;
        cost_wa      = s_cell;
        cost_wd.seen = 1'b1;
        open_we      = 1'b1;
        open_wa      = '0;
        open_wd.loc  = s_cell;
        open_wd.g    = '0;
        open_wd.f    = {8'b0, heur(s_cell, cfg)};
        ocnt_nxt     = 10'd1;
      end
      S_POP: begin
        ri_nxt = '0;
        if (ocnt_r == 10'd0) status_nxt = STAT_NOPATH;
      end
      // find the lowest f over the open list
      S_SCAN: begin
        if ((ri_r != 10'd0) && take) begin
          bestf_nxt = open_rd.f;
          pick_nxt  = ri_m1[OpenAw-1:0];
          cur_nxt   = open_rd;
        end
        if (ri_r == ocnt_r) begin
          ri_nxt = {1'b0, pick_nxt} + 10'd1;
          pv_nxt = 1'b0;
        end else begin
          ri_nxt = ri_r + 10'd1;
        end
      end
      // close the gap left by the popped entry
      S_SHIFT: begin
        cost_ra = cur_r.loc;
        open_we = pv_r;
        open_wa = wa_r;
        open_wd = open_rd;
        if (ri_r < ocnt_r) begin
          pv_nxt = 1'b1;
          wa_nxt = ri_m1[OpenAw-1:0];
          ri_nxt = ri_r + 10'd1;
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) ocnt_nxt = ocnt_r - 10'd1;
        end
      end
      // stale test and goal test
      S_CHK: begin
        k_nxt     = '0;
        pcell_nxt = e_cell;
        pn_nxt    = '0;
      end
      // issue neighbor reads
      S_NB: begin
        nc_nxt = nb_cell;
        if (!nb_in) k_nxt = k_r + 3'd1;
      end
      // relax one neighbor
      S_NBE: begin
        k_nxt = k_r + 3'd1;
        if (!nb_skip) begin
          if (ocnt_r[9]) begin
            status_nxt = STAT_OVERFLOW;
          end else begin
            cost_we      = 1'b1;
            cost_wa      = nc_r;
            cost_wd.seen = 1'b1;
            cost_wd.best = ng;
            par_we       = 1'b1;
            open_we      = 1'b1;
            open_wd.loc  = nc_r;
            open_wd.g    = ng;
            open_wd.f    = {1'b0, ng} + {8'b0, heur(nc_r, cfg)};
            ocnt_nxt     = ocnt_r + 10'd1;
          end
        end
      end
      // store path goal first, read it back reversed
      S_PW: begin
        if (pn_r[8]) begin
          status_nxt = STAT_NOPATH;
        end else begin
          path_we = 1'b1;
          pn_nxt  = pn_r + 9'd1;
          if (pcell_r == s_cell) pc_nxt = pn_r + 9'd1;
        end
      end
      S_PR: begin
        pcell_nxt = {pcell_r[7:4] - {{2{pdy[1]}}, pdy},
                     pcell_r[3:0] - {{2{pdx[1]}}, pdx}};
      end
      S_PRD: pt_nxt = path_rd;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= '0;
      ocnt_r  <= '0;
      pc_r    <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ocnt_r  <= ocnt_nxt;
      pc_r    <= pc_nxt;
      pv_r    <= pv_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ri_r     <= ri_nxt;
    wa_r     <= wa_nxt;
    pick_r   <= pick_nxt;
    bestf_r  <= bestf_nxt;
    cur_r    <= cur_nxt;
    k_r      <= k_nxt;
    nc_r     <= nc_nxt;
    pn_r     <= pn_nxt;
    pcell_r  <= pcell_nxt;
    op_r     <= op_nxt;
    status_r <= status_nxt;
    pt_r     <= pt_nxt;
  end

  gasu_ram #(.WIDTH(1), .DEPTH(CellCount)) u_wall (
    .clk(clk), .we(wall_we), .waddr(wall_wa), .wdata(wall_wd),
    .raddr(wall_ra), .rdata(wall_rd)
  );

  gasu_ram #(.WIDTH(CostW + 1), .DEPTH(CellCount)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd),
    .raddr(cost_ra), .rdata(cost_rd)
  );

  gasu_ram #(.WIDTH(3), .DEPTH(CellCount)) u_parent (
    .clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd),
    .raddr(par_ra), .rdata(par_rd)
  );

  gasu_ram #(.WIDTH(CellW + CostW + FW), .DEPTH(OpenDepth)) u_open (
    .clk(clk), .we(open_we), .waddr(open_wa), .wdata(open_wd),
    .raddr(open_ra), .rdata(open_rd)
  );

  gasu_ram #(.WIDTH(CellW), .DEPTH(CellCount)) u_path (
    .clk(clk), .we(path_we), .waddr(path_wa), .wdata(path_wd),
    .raddr(path_ra), .rdata(path_rd)
  );

endmodule

>>> hdl/grid_astar_path_search_unit.sv
// top level: register port, command and result words, search engine
//
//  channel | direction | contents
//  in_     | slave     | command word: tuser opcode, tdata cell and path index
//  out_    | master    | result word: tuser status, tdata length and point
//  cfg_    | apb slave | eight 32-bit registers at byte address 4*i
//
//  After reset the wall map is swept clear; in_tready stays low meanwhile.
//  A wall write or opcode 3 goes straight to the result; a path point read
//  reads the path memory first unless the index is past the stored length.
//  A search sweeps the cost map, then each pop scans the open list and
//  closes its gap, and each expansion works through its neighbors on the
//  cost and wall memories; the found path is walked back cell by cell.
//  A new word is taken while the previous result waits in the output register.
module grid_astar_path_search_unit
  import gasu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cell_x[3:0], cell_y[7:4], path_index[15:8]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // path_length[8:0], point_x[12:9], point_y[16:13]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t  cfg_r;
  cmd_t  cmd;
  res_t  res;
  logic  res_valid, res_ready;
  logic  out_valid_r;
  logic [23:0] out_tdata_r;
  logic [1:0]  out_tuser_r;
  logic  cfg_wr;
  reg_t  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_t'(cfg_paddr[4:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width    <= 5'd16;
      cfg_r.grid_height   <= 5'd16;
      cfg_r.start_x       <= 4'd0;
      cfg_r.start_y       <= 4'd0;
      cfg_r.end_x         <= 4'd15;
      cfg_r.end_y         <= 4'd15;
      cfg_r.straight_cost <= 4'd1;
      cfg_r.diagonal_cost <= 4'd1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GRID_W:  cfg_r.grid_width    <= cfg_pwdata[4:0];
        REG_GRID_H:  cfg_r.grid_height   <= cfg_pwdata[4:0];
        REG_START_X: cfg_r.start_x       <= cfg_pwdata[3:0];
        REG_START_Y: cfg_r.start_y       <= cfg_pwdata[3:0];
        REG_END_X:   cfg_r.end_x         <= cfg_pwdata[3:0];
        REG_END_Y:   cfg_r.end_y         <= cfg_pwdata[3:0];
        REG_SCOST:   cfg_r.straight_cost <= cfg_pwdata[3:0];
        REG_DCOST:   cfg_r.diagonal_cost <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (cfg_idx)
      REG_GRID_W:  cfg_prdata = {27'b0, cfg_r.grid_width};
      REG_GRID_H:  cfg_prdata = {27'b0, cfg_r.grid_height};
      REG_START_X: cfg_prdata = {28'b0, cfg_r.start_x};
      REG_START_Y: cfg_prdata = {28'b0, cfg_r.start_y};
      REG_END_X:   cfg_prdata = {28'b0, cfg_r.end_x};
      REG_END_Y:   cfg_prdata = {28'b0, cfg_r.end_y};
      REG_SCOST:   cfg_prdata = {28'b0, cfg_r.straight_cost};
      REG_DCOST:   cfg_prdata = {28'b0, cfg_r.diagonal_cost};
      default:     cfg_prdata = '0;
    endcase
  end

  // command word unpack
  always_comb begin
    cmd.opcode     = in_tuser;
    cmd.cell_x     = in_tdata[3:0];
    cmd.cell_y     = in_tdata[7:4];
    cmd.path_index = in_tdata[15:8];
  end

  gasu_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .cmd_valid(in_tvalid), .cmd_ready(in_tready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tuser_r <= res.status;
      out_tdata_r <= {7'b0, res.point_y, res.point_x, res.path_length};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
